// ----- src/svp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types, codes and defaults of the sampler voice playback block.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int STORE_FRAMES_DEF = 4096;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_FRAME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_FRAME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEFT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_RIGHT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 3'd7;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_TRIGGER = 2'd1;
    localparam logic [1:0] FUNC_TICK    = 2'd2;

    localparam logic [19:0] RATE_STEP_RST    = 20'h10000;
    localparam logic [12:0] FRAME_COUNT_RST  = 13'd4096;
    localparam logic [15:0] GAIN_RST         = 16'h8000;
    localparam logic [15:0] RELEASE_STEP_RST = 16'd16;
    localparam logic [16:0] ENV_UNITY        = 17'h10000;

    typedef struct packed {
        logic [1:0]         func;
        logic [11:0]        frame_addr;
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic [15:0]        velocity;
        logic               gate_enable;
        logic [23:0]        gate_frames;
    } svp_req_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic               voice_active;
    } svp_res_t;

endpackage

// ----- src/svp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_if
// Valid/ready channels carrying requests into and results out of the voice.
// ----------------------------------------------------------------------------
interface svp_req_if
    import svp_pkg::*;
();
    logic     valid;
    logic     ready;
    svp_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface svp_res_if
    import svp_pkg::*;
();
    logic     valid;
    logic     ready;
    svp_res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/sampler_voice_playback.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampler_voice_playback
// One sampler voice: sample store, trigger, interpolated and enveloped ticks.
// ----------------------------------------------------------------------------
// A tick on a playing voice steps through RD1, RD2, LRP and ENV: the sample
// memory has a single read port, so the two neighboring frames are read in
// consecutive cycles, followed by the interpolation multiply, the gain
// multiply and the envelope multiply. A tick on a silent voice, or one that
// reaches the end frame, goes to ZERO; one that exhausts the release goes
// through RD1 and RD2 to ZERO. A finished result sits in an output register
// while the next request is accepted; a tick only stalls at its last step if
// the previous result has not been taken yet. The sample memory has no reset,
// so reading a frame that was never written returns garbage.
module sampler_voice_playback
    import svp_pkg::*;
#(
    parameter int STORE_FRAMES = STORE_FRAMES_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    svp_req_if.sink              req,
    svp_res_if.source            res
);

    localparam int AW    = $clog2(STORE_FRAMES);
    localparam int FRM_W = (AW + 1 > 12) ? AW + 1 : 12;
    localparam int POS_W = FRM_W + FRAC_BITS;
    localparam int SUM_W = ((POS_W > 20) ? POS_W : 20) + 1;
    localparam int CMP_W = FRM_W + 1;
    localparam int WA_W  = (AW > 12) ? AW : 12;
    localparam int PRD_W = FRAC_BITS + 18;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(STORE_FRAMES) << FRAC_BITS;
    localparam logic [CMP_W-1:0] LAST_MAX  = CMP_W'(STORE_FRAMES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;
    localparam logic [2:0] S_RD2  = 3'd2;
    localparam logic [2:0] S_LRP  = 3'd3;
    localparam logic [2:0] S_ENV  = 3'd4;
    localparam logic [2:0] S_ZERO = 3'd5;

    function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
        logic signed [50:0] s;
        s = v >>> 31;
        if (s > 51'sd32767)
            return 16'sh7FFF;
        else if (s < -51'sd32768)
            return 16'sh8000;
        else
            return s[15:0];
    endfunction

    // configuration
    logic [19:0] rate_step_reg;
    logic [11:0] start_frame_reg;
    logic [12:0] end_frame_reg;
    logic [12:0] frame_count_reg;
    logic        stereo_reg;
    logic [15:0] gain_left_reg;
    logic [15:0] gain_right_reg;
    logic [15:0] release_step_reg;

    // voice state
    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic             active_reg;
    logic [POS_W-1:0] pos_reg;
    logic [15:0]      left_gain_reg;
    logic [15:0]      right_gain_reg;
    logic [23:0]      gate_left_reg;
    logic             gate_on_reg;
    logic [16:0]      env_reg;

    // sample memory, left in the upper half
    logic [31:0]   mem [STORE_FRAMES];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [WA_W-1:0] waddr_ext;
    logic          mem_we;

    // datapath
    logic signed [15:0]      a_l_reg;
    logic signed [15:0]      a_r_reg;
    logic signed [PRD_W-1:0] prod_l_reg;
    logic signed [PRD_W-1:0] prod_r_reg;
    logic signed [32:0]      pg_l_reg;
    logic signed [32:0]      pg_r_reg;

    logic               out_valid_reg;
    svp_res_t           out_data_reg;

    logic               req_fire;
    logic               out_free;
    logic [FRM_W-1:0]   frame_cur;
    logic [12:0]        last_sel;
    logic [CMP_W-1:0]   last_cmp;
    logic               at_end;
    logic               env_stop;
    logic [SUM_W-1:0]   pos_sum;
    logic [POS_W-1:0]   pos_step;
    logic [31:0]        vel_l;
    logic [31:0]        vel_r;
    logic [15:0]        trig_gain_l;
    logic [15:0]        trig_gain_r;
    logic signed [16:0] diff_l;
    logic signed [16:0] diff_r;
    logic signed [PRD_W-1:0] sh_l;
    logic signed [PRD_W-1:0] sh_r;
    logic signed [17:0] lerp_l18;
    logic signed [17:0] lerp_r18;
    logic signed [15:0] lerp_l;
    logic signed [15:0] lerp_r;
    logic signed [15:0] samp_r;
    logic signed [50:0] full_l;
    logic signed [50:0] full_r;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || res.ready;
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    // end-of-sample check
    assign frame_cur = pos_reg[POS_W-1:FRAC_BITS];

    always_comb
    begin
        last_sel = (end_frame_reg != 13'd0) ? end_frame_reg : frame_count_reg;
        if (last_sel > frame_count_reg)
            last_sel = frame_count_reg;
        last_cmp = CMP_W'(last_sel);
        if (last_cmp > LAST_MAX)
            last_cmp = LAST_MAX;
    end

    assign at_end = (CMP_W'(frame_cur) + CMP_W'(1)) >= last_cmp;

    assign env_stop = gate_on_reg && (gate_left_reg == 24'd0)
                      && ({1'b0, release_step_reg} >= env_reg);

    always_comb
    begin
        pos_sum = SUM_W'(pos_reg) + SUM_W'(rate_step_reg);
        if (pos_sum > SUM_W'(POS_LIMIT))
            pos_step = POS_LIMIT;
        else
            pos_step = pos_sum[POS_W-1:0];
    end

    // trigger gains
    assign vel_l       = gain_left_reg * req.data.velocity;
    assign vel_r       = gain_right_reg * req.data.velocity;
    assign trig_gain_l = vel_l[31] ? 16'hFFFF : vel_l[30:15];
    assign trig_gain_r = vel_r[31] ? 16'hFFFF : vel_r[30:15];

    // memory access
    assign waddr_ext = WA_W'(req.data.frame_addr);
    assign waddr     = waddr_ext[AW-1:0];
    assign mem_we    = req_fire && (req.data.func == FUNC_WRITE)
                       && ({20'd0, req.data.frame_addr} < 32'(STORE_FRAMES));
    assign raddr     = frame_cur[AW-1:0] + AW'(state_reg == S_RD1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= {req.data.sample_left, req.data.sample_right};
        rd_data_reg <= mem[raddr];
    end

    // interpolation and scaling
    assign diff_l = {rd_data_reg[31], rd_data_reg[31:16]} - {a_l_reg[15], a_l_reg};
    assign diff_r = {rd_data_reg[15], rd_data_reg[15:0]} - {a_r_reg[15], a_r_reg};

    assign sh_l     = prod_l_reg >>> FRAC_BITS;
    assign sh_r     = prod_r_reg >>> FRAC_BITS;
    assign lerp_l18 = sh_l[17:0] + {{2{a_l_reg[15]}}, a_l_reg};
    assign lerp_r18 = sh_r[17:0] + {{2{a_r_reg[15]}}, a_r_reg};
    assign lerp_l   = lerp_l18[15:0];
    assign lerp_r   = lerp_r18[15:0];
    assign samp_r   = stereo_reg ? lerp_r : lerp_l;

    assign full_l = pg_l_reg * $signed({1'b0, env_reg});
    assign full_r = pg_r_reg * $signed({1'b0, env_reg});

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD1)
        begin
            a_l_reg <= rd_data_reg[31:16];
            a_r_reg <= rd_data_reg[15:0];
        end
        if (state_reg == S_RD2)
        begin
            prod_l_reg <= diff_l * $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
            prod_r_reg <= diff_r * $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
        end
        if (state_reg == S_LRP)
        begin
            pg_l_reg <= lerp_l * $signed({1'b0, left_gain_reg});
            pg_r_reg <= samp_r * $signed({1'b0, right_gain_reg});
        end
        if (state_reg == S_ENV && out_free)
        begin
            out_data_reg.out_left     <= sat16(full_l);
            out_data_reg.out_right    <= sat16(full_r);
            out_data_reg.voice_active <= 1'b1;
        end
        else if (state_reg == S_ZERO && out_free)
        begin
            out_data_reg.out_left     <= 16'sd0;
            out_data_reg.out_right    <= 16'sd0;
            out_data_reg.voice_active <= 1'b0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && req.data.func == FUNC_TICK)
                begin
                    if (!active_reg || at_end)
                        state_next = S_ZERO;
                    else
                        state_next = S_RD1;
                end
            end
            S_RD1:
                state_next = S_RD2;
            S_RD2:
                state_next = env_stop ? S_ZERO : S_LRP;
            S_LRP:
                state_next = S_ENV;
            S_ENV, S_ZERO:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_step_reg    <= RATE_STEP_RST;
            start_frame_reg  <= '0;
            end_frame_reg    <= '0;
            frame_count_reg  <= FRAME_COUNT_RST;
            stereo_reg       <= 1'b0;
            gain_left_reg    <= GAIN_RST;
            gain_right_reg   <= GAIN_RST;
            release_step_reg <= RELEASE_STEP_RST;
            state_reg        <= S_IDLE;
            active_reg       <= 1'b0;
            pos_reg          <= '0;
            left_gain_reg    <= '0;
            right_gain_reg   <= '0;
            gate_left_reg    <= '0;
            gate_on_reg      <= 1'b0;
            env_reg          <= ENV_UNITY;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RATE_STEP:    rate_step_reg    <= cfg_data;
                    REG_START_FRAME:  start_frame_reg  <= cfg_data[11:0];
                    REG_END_FRAME:    end_frame_reg    <= cfg_data[12:0];
                    REG_FRAME_COUNT:  frame_count_reg  <= cfg_data[12:0];
                    REG_STEREO:       stereo_reg       <= cfg_data[0];
                    REG_GAIN_LEFT:    gain_left_reg    <= cfg_data[15:0];
                    REG_GAIN_RIGHT:   gain_right_reg   <= cfg_data[15:0];
                    REG_RELEASE_STEP: release_step_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (state_reg == S_IDLE && req_fire)
            begin
                if (req.data.func == FUNC_TRIGGER && !active_reg)
                begin
                    active_reg     <= 1'b1;
                    pos_reg        <= POS_W'(start_frame_reg) << FRAC_BITS;
                    left_gain_reg  <= trig_gain_l;
                    right_gain_reg <= trig_gain_r;
                    gate_on_reg    <= req.data.gate_enable;
                    gate_left_reg  <= req.data.gate_frames;
                    env_reg        <= ENV_UNITY;
                end
                else if (req.data.func == FUNC_TICK && active_reg && at_end)
                    active_reg <= 1'b0;
            end

            if (state_reg == S_RD2)
            begin
                if (env_stop)
                begin
                    env_reg    <= '0;
                    active_reg <= 1'b0;
                end
                else
                begin
                    if (gate_on_reg && gate_left_reg == 24'd0)
                        env_reg <= env_reg - {1'b0, release_step_reg};
                    else if (gate_on_reg)
                        gate_left_reg <= gate_left_reg - 24'd1;
                    pos_reg <= pos_step;
                end
            end

            if ((state_reg == S_ENV || state_reg == S_ZERO) && out_free)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // checks
    a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
        env_reg <= ENV_UNITY)
        else $error("envelope above unity");

    a_stop_source: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> ($past(state_reg) == S_IDLE || $past(state_reg) == S_RD2))
        else $error("voice stopped outside a tick");

    a_silent_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.data.func == FUNC_TICK && !active_reg) |=> state_reg == S_ZERO)
        else $error("tick on silent voice did not take the zero path");

endmodule
